>>> rtl/action_list_validator_defines.svh
// ----------------------------------------------------------------------------
// Action list validator assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ACTION_LIST_VALIDATOR_DEFINES_SVH
`define ACTION_LIST_VALIDATOR_DEFINES_SVH

// Checked only outside reset
`define ALV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ALV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/alv_pkg.sv
// ----------------------------------------------------------------------------
// Action list validator package
// Status codes, action code values and the types shared by the modules.
// ----------------------------------------------------------------------------
package alv_pkg;

    localparam int SLOT_W     = 64;
    localparam int SLOT_CNT_W = 13;
    localparam int LIMIT_W    = 32;

    localparam logic [15:0] TYPE_OUTPUT       = 16'h0000;
    localparam logic [15:0] TYPE_SET_QUEUE    = 16'h0015;
    localparam logic [15:0] TYPE_EXPERIMENTER = 16'hFFFF;
    localparam logic [31:0] VENDOR_ID         = 32'h0000_2320;
    localparam logic [15:0] SUB_RESUBMIT      = 16'd1;
    localparam logic [15:0] SUB_SET_TUNNEL    = 16'd2;
    localparam logic [31:0] PORT_TABLE        = 32'hFFFF_FFF9;
    localparam logic [15:0] LEN_ONE_SLOT      = 16'd8;
    localparam logic [15:0] LEN_TWO_SLOTS     = 16'd16;
    localparam logic [LIMIT_W-1:0] PORT_LIMIT_RST = 32'd64;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_BAD_PORT = 3'd2,
        ST_BAD_EXP  = 3'd3,
        ST_BAD_TYPE = 3'd4
    } t_status;

    // Per-list flags carried from slot to slot
    typedef struct packed {
        logic    await_sub;  // next slot holds an experimenter subtype
        logic    pend16;     // that experimenter action is exactly 16 bytes
        logic    tbl;        // table port permitted for this list
        t_status latched;    // first error of the list
    } t_flags;

    typedef struct packed {
        logic [SLOT_W-1:0]     word;
        logic [SLOT_CNT_W-1:0] cnt;
        logic                  tbl;
    } t_slot;

endpackage

>>> rtl/action_list_validator.sv
// ----------------------------------------------------------------------------
// Action list validator
// Checks a streamed action list slot by slot and reports one status per list.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_slot_word, i_slot_count,
//                                                i_table_allowed
//  out      output     o_out_valid / i_out_stall o_status
//  cfg      input      i_cfg_wr_en               i_cfg_wr_data (port limit)
//
// One slot request per cycle while o_in_stall is low; a list's status passes from
// the input register through the check logic into the result register when the
// check stage takes its last slot.
// Only a full result register held by i_out_stall stops the check stage.
// Reset closes any open list, drops both registers and sets port limit to 64.
// ----------------------------------------------------------------------------
module action_list_validator #(
    parameter int MAX_SLOTS = 8191
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [alv_pkg::SLOT_W-1:0]       i_slot_word,
    input  logic [alv_pkg::SLOT_CNT_W-1:0]   i_slot_count,
    input  logic                             i_table_allowed,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_status,
    input  logic                             i_cfg_wr_en,
    input  logic [alv_pkg::LIMIT_W-1:0]      i_cfg_wr_data
);
    import alv_pkg::*;

    localparam int CW = $clog2(MAX_SLOTS+1);

    logic [LIMIT_W-1:0] r_port_limit;
    logic [CW-1:0]      r_list_rem;
    logic [CW-1:0]      r_act_rem;
    t_flags             r_flags;
    logic               r_out_valid;
    t_status            r_status;

    logic [CW-1:0]      n_list_rem;
    logic [CW-1:0]      n_act_rem;
    t_flags             n_flags;
    logic               res_valid;
    t_status            res_status;

    t_slot              in_slot;
    t_slot              s1_slot;
    logic               s1_valid;
    logic               take;
    logic               out_free;

    assign in_slot = '{word: i_slot_word, cnt: i_slot_count, tbl: i_table_allowed};

    alv_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_slot  (in_slot),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_slot  (s1_slot)
    );

    alv_slot_check #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_check (
        .i_list_rem   (r_list_rem),
        .i_act_rem    (r_act_rem),
        .i_flags      (r_flags),
        .i_port_limit (r_port_limit),
        .i_slot       (s1_slot),
        .o_list_rem   (n_list_rem),
        .o_act_rem    (n_act_rem),
        .o_flags      (n_flags),
        .o_res_valid  (res_valid),
        .o_res_status (res_status)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = s1_valid && (!res_valid || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_limit <= PORT_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_port_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_rem <= '0;
            r_act_rem  <= '0;
            r_flags    <= '{await_sub: 1'b0, pend16: 1'b0, tbl: 1'b0, latched: ST_OK};
        end else if (take) begin
            r_list_rem <= n_list_rem;
            r_act_rem  <= n_act_rem;
            r_flags    <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_status <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

>>> rtl/alv_in_reg.sv
// ----------------------------------------------------------------------------
// Action list validator input register
// Captures one slot request and holds it until the check stage takes it.
// ----------------------------------------------------------------------------
module alv_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  alv_pkg::t_slot i_slot,
    input  logic          i_take,
    output logic          o_valid,
    output alv_pkg::t_slot o_slot
);
    import alv_pkg::*;

    logic  r_valid;
    t_slot r_slot;
    logic  accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot <= i_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

>>> rtl/alv_slot_check.sv
// ----------------------------------------------------------------------------
// Action list validator slot check
// Next-state and status logic for one slot against the open list.
// ----------------------------------------------------------------------------
module alv_slot_check #(
    parameter int MAX_SLOTS = 8191
) (
    input  logic [$clog2(MAX_SLOTS+1)-1:0] i_list_rem,
    input  logic [$clog2(MAX_SLOTS+1)-1:0] i_act_rem,
    input  alv_pkg::t_flags                i_flags,
    input  logic [alv_pkg::LIMIT_W-1:0]    i_port_limit,
    input  alv_pkg::t_slot                 i_slot,
    output logic [$clog2(MAX_SLOTS+1)-1:0] o_list_rem,
    output logic [$clog2(MAX_SLOTS+1)-1:0] o_act_rem,
    output alv_pkg::t_flags                o_flags,
    output logic                           o_res_valid,
    output alv_pkg::t_status               o_res_status
);
    import alv_pkg::*;

    localparam int CW = $clog2(MAX_SLOTS+1);

    logic [15:0]           h_type;
    logic [15:0]           h_len;
    logic [31:0]           h_low;
    logic [SLOT_CNT_W-1:0] nslots;
    logic [SLOT_CNT_W-1:0] cnt_c;
    logic                  reserved;
    logic                  port_ok;

    assign h_type = i_slot.word[63:48];
    assign h_len  = i_slot.word[47:32];
    assign h_low  = i_slot.word[31:0];
    assign nslots = h_len[15:3];
    assign cnt_c  = (i_slot.cnt > SLOT_CNT_W'(MAX_SLOTS)) ? SLOT_CNT_W'(MAX_SLOTS)
                                                           : i_slot.cnt;
    // in_port .. local, all ones except the low three bits
    assign reserved = (&h_low[31:3]) && (h_low[2:0] != 3'b111);

    always_comb begin
        logic [CW-1:0] lr;
        logic [CW-1:0] ar;
        logic [CW-1:0] lr_dec;
        t_flags        fl;
        t_status       err;
        logic          empty;
        logic          tbl_eff;

        lr           = i_list_rem;
        ar           = i_act_rem;
        fl           = i_flags;
        err          = ST_OK;
        empty        = 1'b0;
        o_res_valid  = 1'b0;
        o_res_status = ST_OK;

        // first slot opens a new list
        if (i_list_rem == '0) begin
            fl    = '{await_sub: 1'b0, pend16: 1'b0, tbl: i_slot.tbl, latched: ST_OK};
            ar    = '0;
            lr    = CW'(cnt_c);
            empty = (cnt_c == '0);
        end
        tbl_eff = fl.tbl;
        port_ok = reserved ? ((h_low != PORT_TABLE) || tbl_eff) : (h_low < i_port_limit);

        if (!empty && fl.latched == ST_OK) begin
            if (ar == '0) begin
                if ((nslots > SLOT_CNT_W'(lr)) || (h_len == '0) || (h_len[2:0] != 3'd0)) begin
                    err = ST_BAD_LEN;
                end else begin
                    ar = CW'(nslots - SLOT_CNT_W'(1));
                    priority if (h_type == TYPE_OUTPUT) begin
                        if (h_len != LEN_TWO_SLOTS) begin
                            err = ST_BAD_LEN;
                        end else if (!port_ok) begin
                            err = ST_BAD_PORT;
                        end
                    end else if (h_type == TYPE_SET_QUEUE) begin
                        if (h_len != LEN_ONE_SLOT) begin
                            err = ST_BAD_LEN;
                        end
                    end else if (h_type == TYPE_EXPERIMENTER) begin
                        if (h_low != VENDOR_ID) begin
                            err = ST_BAD_EXP;
                        end else if (h_len < LEN_TWO_SLOTS) begin
                            err = ST_BAD_LEN;
                        end else begin
                            fl.await_sub = 1'b1;
                            fl.pend16    = (h_len == LEN_TWO_SLOTS);
                        end
                    end else begin
                        err = ST_BAD_TYPE;
                    end
                end
            end else begin
                if (fl.await_sub) begin
                    if (h_type == SUB_RESUBMIT || h_type == SUB_SET_TUNNEL) begin
                        err = fl.pend16 ? ST_OK : ST_BAD_LEN;
                    end else begin
                        err = ST_BAD_EXP;
                    end
                    fl.await_sub = 1'b0;
                end
                ar = ar - CW'(1);
            end
            if (err != ST_OK) begin
                fl.latched   = err;
                fl.await_sub = 1'b0;
                ar           = '0;
            end
        end

        lr_dec = lr - CW'(1);
        if (empty) begin
            o_res_valid  = 1'b1;
            o_res_status = ST_OK;
            lr           = '0;
        end else if (lr_dec == '0) begin
            // last slot of the list: report and close
            o_res_valid  = 1'b1;
            o_res_status = fl.latched;
            lr           = '0;
            ar           = '0;
            fl           = '{await_sub: 1'b0, pend16: 1'b0, tbl: 1'b0, latched: ST_OK};
        end else begin
            lr = lr_dec;
        end

        o_list_rem = lr;
        o_act_rem  = ar;
        o_flags    = fl;
    end

endmodule

>>> rtl/alv_checker.sv
// ----------------------------------------------------------------------------
// Action list validator checker
// Port-level properties of the validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "action_list_validator_defines.svh"

module alv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status
);
    import alv_pkg::*;

    // the input side only backs up behind a held result
    `ALV_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stall without a held result")
    `ALV_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_status <= 3'(ST_BAD_TYPE)), "status code out of range")
    `ALV_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)), "stalled result dropped or changed")
    `ALV_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "activity right after reset")

endmodule

bind action_list_validator alv_checker u_alv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status)
);
